// File: hw/rtl/ptt_pkg.sv
// Shared types and constants for the pan/tilt target tracker.
// No dependencies; every other file of the block imports this package.
package ptt_pkg;

	localparam int POS_W      = 10;  // pixel coordinate
	localparam int ANG_W      = 12;  // signed angle
	localparam int DB_W       = 17;  // deadband, Q1.16
	localparam int GAIN_W     = 16;  // Q4.12 gain
	localparam int STEP_W     = 10;  // full-scale step and slew
	localparam int MAG_W      = 17;  // error magnitude, Q1.16
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int NUM_STAGES = 5;

	localparam logic [MAG_W-1:0] ERR_MAX_MAG = 17'h1FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND   = 3'd0,
		REG_YAW_GAIN   = 3'd1,
		REG_YAW_FULL   = 3'd2,
		REG_YAW_SLEW   = 3'd3,
		REG_PITCH_GAIN = 3'd4,
		REG_PITCH_FULL = 3'd5,
		REG_PITCH_SLEW = 3'd6
	} ptt_reg_t;

	localparam logic [DB_W-1:0]   RST_DEADBAND   = 17'd6554;
	localparam logic [GAIN_W-1:0] RST_YAW_GAIN   = 16'd4096;
	localparam logic [STEP_W-1:0] RST_YAW_FULL   = 10'd30;
	localparam logic [STEP_W-1:0] RST_YAW_SLEW   = 10'd5;
	localparam logic [GAIN_W-1:0] RST_PITCH_GAIN = 16'd4096;
	localparam logic [STEP_W-1:0] RST_PITCH_FULL = 10'd20;
	localparam logic [STEP_W-1:0] RST_PITCH_SLEW = 10'd5;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic [STEP_W-1:0] full;
		logic [STEP_W-1:0] slew;
	} ptt_axis_cfg_t;

	typedef struct packed {
		logic [DB_W-1:0] deadband;
		ptt_axis_cfg_t   yaw;
		ptt_axis_cfg_t   pitch;
	} ptt_cfg_t;

	// one load strobe per pipeline stage
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} ptt_stage_ctl_t;

endpackage

// File: hw/rtl/ptt_in_if.sv
// Input channel: target position and present angles, valid/ready.
// Depends on ptt_pkg for field widths.
interface ptt_in_if;
	import ptt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [POS_W-1:0]         target_x;
	logic [POS_W-1:0]         target_y;
	logic signed [ANG_W-1:0]  current_yaw;
	logic signed [ANG_W-1:0]  current_pitch;

	modport source (output valid, target_x, target_y, current_yaw, current_pitch,
		input ready);
	modport sink (input valid, target_x, target_y, current_yaw, current_pitch,
		output ready);
endinterface

// File: hw/rtl/ptt_out_if.sv
// Output channel: commanded angles and move flag, valid/ready.
// Depends on ptt_pkg for field widths.
interface ptt_out_if;
	import ptt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [ANG_W-1:0]  next_yaw;
	logic signed [ANG_W-1:0]  next_pitch;
	logic                     should_move;

	modport source (output valid, next_yaw, next_pitch, should_move, input ready);
	modport sink (input valid, next_yaw, next_pitch, should_move, output ready);
endinterface

// File: hw/rtl/ptt_cfg_if.sv
// Configuration write channel: register index and data, valid/ready.
// Depends on ptt_pkg for widths.
interface ptt_cfg_if;
	import ptt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ptt_cfg_regs.sv
// Configuration register file of the tracker.
// Depends on ptt_pkg (register codes, reset values, ptt_cfg_t).
module ptt_cfg_regs
	import ptt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output ptt_cfg_t              cfg
);

	ptt_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband   <= RST_DEADBAND;
			cfg_q.yaw.gain   <= RST_YAW_GAIN;
			cfg_q.yaw.full   <= RST_YAW_FULL;
			cfg_q.yaw.slew   <= RST_YAW_SLEW;
			cfg_q.pitch.gain <= RST_PITCH_GAIN;
			cfg_q.pitch.full <= RST_PITCH_FULL;
			cfg_q.pitch.slew <= RST_PITCH_SLEW;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEADBAND:   cfg_q.deadband   <= wr_data[DB_W-1:0];
				REG_YAW_GAIN:   cfg_q.yaw.gain   <= wr_data[GAIN_W-1:0];
				REG_YAW_FULL:   cfg_q.yaw.full   <= wr_data[STEP_W-1:0];
				REG_YAW_SLEW:   cfg_q.yaw.slew   <= wr_data[STEP_W-1:0];
				REG_PITCH_GAIN: cfg_q.pitch.gain <= wr_data[GAIN_W-1:0];
				REG_PITCH_FULL: cfg_q.pitch.full <= wr_data[STEP_W-1:0];
				REG_PITCH_SLEW: cfg_q.pitch.slew <= wr_data[STEP_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/ptt_axis.sv
// Five-stage datapath for one axis: error, deadband, gain step, slew and clamp.
// Depends on ptt_pkg; stage loads come from the control in the top level.
module ptt_axis
	import ptt_pkg::*;
#(
	parameter int FRAME = 320,
	parameter int LO    = -90,
	parameter int HI    = 90
) (
	input  logic                     clk,
	input  ptt_stage_ctl_t           ctl,
	input  logic [POS_W-1:0]         pos,
	input  logic signed [ANG_W-1:0]  cur,
	input  logic [DB_W-1:0]          deadband,
	input  ptt_axis_cfg_t            acfg,
	output logic signed [ANG_W-1:0]  next_angle,
	output logic                     moved
);

	// error = round(diff * 2^16 / F) via reciprocal 2^27/F and one correction step
	localparam logic [10:0]            F_V   = 11'(FRAME);
	localparam logic [11:0]            D_V   = 12'(2 * FRAME);
	localparam logic [26:0]            RECIP = 27'((64'd1 << 27) / FRAME);
	localparam logic signed [ANG_W:0]  LO_V  = 13'(LO);
	localparam logic signed [ANG_W:0]  HI_V  = 13'(HI);

	// stage 1
	logic [10:0]              twice, diff;
	logic                     neg;
	logic [10:0]              diff_s1;
	logic [37:0]              prod_s1;
	logic                     neg_s1, sat_s1;
	logic signed [ANG_W-1:0]  cur_s1;

	always_comb begin
		twice = {pos, 1'b0};
		neg   = twice < F_V;
		diff  = neg ? (F_V - twice) : (twice - F_V);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			diff_s1 <= diff;
			prod_s1 <= 38'(diff) * 38'(RECIP);
			neg_s1  <= neg;
			sat_s1  <= {1'b0, diff} >= D_V;
			cur_s1  <= cur;
		end
	end

	// stage 2: quotient estimate is exact or one low
	logic [37:0]              rnd;
	logic [17:0]              q0;
	logic [29:0]              num, qd;
	logic                     inc;
	logic [MAG_W-1:0]         mag_s2;
	logic                     neg_s2;
	logic signed [ANG_W-1:0]  cur_s2;

	always_comb begin
		rnd = prod_s1 + 38'd1024;
		q0  = rnd[28:11];
		num = 30'({diff_s1, 17'd0}) + 30'(F_V);
		qd  = 30'(q0) * 30'(D_V);
		inc = (qd + 30'(D_V)) <= num;
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			mag_s2 <= sat_s1 ? ERR_MAX_MAG : MAG_W'(q0 + 18'(inc));
			neg_s2 <= neg_s1;
			cur_s2 <= cur_s1;
		end
	end

	// stage 3
	logic [32:0]              mg_s3;
	logic                     dead_s3, neg_s3;
	logic signed [ANG_W-1:0]  cur_s3;

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			mg_s3   <= 33'(mag_s2) * 33'(acfg.gain);
			dead_s3 <= mag_s2 < deadband;
			neg_s3  <= neg_s2;
			cur_s3  <= cur_s2;
		end
	end

	// stage 4: step magnitude from the product in 2^-28 units, rounded half up
	logic [43:0]              pr;
	logic [15:0]              step_s4;
	logic                     dead_s4, neg_s4;
	logic signed [ANG_W-1:0]  cur_s4;

	always_comb begin
		pr = 44'(mg_s3) * 44'(acfg.full) + (44'd1 << 27);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			step_s4 <= pr[43:28];
			dead_s4 <= dead_s3;
			neg_s4  <= neg_s3;
			cur_s4  <= cur_s3;
		end
	end

	// stage 5: target left of center moves the angle up, right moves it down
	logic [STEP_W-1:0]        lim;
	logic signed [ANG_W:0]    lim_x, delta, tot, clp;
	logic signed [ANG_W-1:0]  nxt;
	logic signed [ANG_W-1:0]  next_s5;
	logic                     moved_s5;

	always_comb begin
		lim   = (step_s4 > 16'(acfg.slew)) ? acfg.slew : step_s4[STEP_W-1:0];
		lim_x = $signed({3'b000, lim});
		delta = neg_s4 ? lim_x : -lim_x;
		tot   = {cur_s4[ANG_W-1], cur_s4} + delta;
		if (tot < LO_V) begin
			clp = LO_V;
		end else if (tot > HI_V) begin
			clp = HI_V;
		end else begin
			clp = tot;
		end
		nxt = dead_s4 ? cur_s4 : clp[ANG_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			next_s5  <= nxt;
			moved_s5 <= nxt != cur_s4;
		end
	end

	assign next_angle = next_s5;
	assign moved      = moved_s5;

endmodule

// File: hw/rtl/pan_tilt_target_tracker.sv
// Pan/tilt target tracker: proportional step with deadband, slew limit and clamp.
// Depends on ptt_pkg, ptt_in_if, ptt_out_if, ptt_cfg_if, ptt_cfg_regs, ptt_axis.
//
// Usage:
//   target  - input beats: target_x/target_y pixel centre and present yaw/pitch.
//   command - result beats: next_yaw, next_pitch, should_move; one per input beat,
//             in order.
//   cfg     - register writes (index 0..6); always ready, takes effect next cycle.
//             Write only while no beat is in flight.
// Timing: a five-stage pipeline, the last stage being the output register.
//   A beat moves through the stages in order; command.valid rises once it reaches
//   the output register, and the beat is taken when command.ready is high.
//   Throughput is one beat per cycle while command.ready is high; the error
//   divide is a reciprocal multiply plus a correction, each multiply in its own stage.
// Stall: each stage holds when the one after it is full and stalled, so bubbles
//   close up and up to five beats are held while command.ready is low; target.ready
//   drops only when all stages are full.
// Reset: arst_n clears all stage valid bits and loads the default register values.
module pan_tilt_target_tracker
	import ptt_pkg::*;
#(
	parameter int FRAME_WIDTH  = 320,
	parameter int FRAME_HEIGHT = 240,
	parameter int YAW_MIN      = -90,
	parameter int YAW_MAX      = 90,
	parameter int PITCH_MIN    = -30,
	parameter int PITCH_MAX    = 30
) (
	input  logic       clk,
	input  logic       arst_n,
	ptt_in_if.sink     target,
	ptt_out_if.source  command,
	ptt_cfg_if.sink    cfg
);

	ptt_cfg_t        cfg_regs;
	ptt_stage_ctl_t  ctl;

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] up_vld;
	logic [NUM_STAGES:0]   rdy;

	assign cfg.ready = 1'b1;

	ptt_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.index),
		.wr_data  (cfg.data),
		.cfg      (cfg_regs)
	);

	// a stage takes a beat when it is empty or its own beat moves on
	always_comb begin
		rdy[NUM_STAGES] = command.ready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
		up_vld   = {vld_q[NUM_STAGES-2:0], target.valid};
		ctl.load = up_vld & rdy[NUM_STAGES-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= up_vld[k];
				end
			end
		end
	end

	assign target.ready = rdy[0];

	logic yaw_moved, pitch_moved;

	ptt_axis #(
		.FRAME (FRAME_WIDTH),
		.LO    (YAW_MIN),
		.HI    (YAW_MAX)
	) u_yaw (
		.clk        (clk),
		.ctl        (ctl),
		.pos        (target.target_x),
		.cur        (target.current_yaw),
		.deadband   (cfg_regs.deadband),
		.acfg       (cfg_regs.yaw),
		.next_angle (command.next_yaw),
		.moved      (yaw_moved)
	);

	ptt_axis #(
		.FRAME (FRAME_HEIGHT),
		.LO    (PITCH_MIN),
		.HI    (PITCH_MAX)
	) u_pitch (
		.clk        (clk),
		.ctl        (ctl),
		.pos        (target.target_y),
		.cur        (target.current_pitch),
		.deadband   (cfg_regs.deadband),
		.acfg       (cfg_regs.pitch),
		.next_angle (command.next_pitch),
		.moved      (pitch_moved)
	);

	assign command.valid       = vld_q[NUM_STAGES-1];
	assign command.should_move = yaw_moved || pitch_moved;

	logic in_beat, out_beat;
	assign in_beat  = target.valid && target.ready;
	assign out_beat = command.valid && command.ready;

	// occupancy tracks beats in and out, nothing lost or duplicated
	a_occ_up: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && !out_beat) |=> ($countones(vld_q) == $past($countones(vld_q)) + 1))
		else $error("pipeline occupancy did not grow on input beat");

	a_occ_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_beat && out_beat) |=> ($countones(vld_q) == $past($countones(vld_q)) - 1))
		else $error("pipeline occupancy did not shrink on output beat");

	a_not_full_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q != '1) |-> target.ready)
		else $error("input stalled while pipeline has a free stage");

endmodule

// File: tb/tb_pan_tilt_target_tracker.sv
`timescale 1ns / 100ps
// Self-checking bench for pan_tilt_target_tracker: queued sightings are driven, commands
// are predicted per axis and compared beat by beat. Needs ptt_pkg and the three channel
// interfaces.
module tb_pan_tilt_target_tracker;
	import ptt_pkg::*;

	localparam int FRAME_W   = 320;
	localparam int FRAME_H   = 240;
	localparam int YAW_LO    = -90;
	localparam int YAW_HI    = 90;
	localparam int PITCH_LO  = -30;
	localparam int PITCH_HI  = 30;

	localparam longint unsigned MAG_CEIL = 131071;  // just under 2.0 in Q1.16
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SETTLE      = 10;
	localparam int JAM_CYCLES  = 60;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [POS_W-1:0]        x;
		logic [POS_W-1:0]        y;
		logic signed [ANG_W-1:0] yaw;
		logic signed [ANG_W-1:0] pitch;
	} sighting_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] yaw;
		logic signed [ANG_W-1:0] pitch;
		logic                    move;
	} aim_t;

	logic clk;
	logic arst_n;

	ptt_in_if  tgt ();
	ptt_out_if cmd ();
	ptt_cfg_if cfgw ();

	pan_tilt_target_tracker #(
		.FRAME_WIDTH (FRAME_W),
		.FRAME_HEIGHT(FRAME_H),
		.YAW_MIN     (YAW_LO),
		.YAW_MAX     (YAW_HI),
		.PITCH_MIN   (PITCH_LO),
		.PITCH_MAX   (PITCH_HI)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.target (tgt),
		.command(cmd),
		.cfg    (cfgw)
	);

	sighting_t detect_q[$];
	aim_t      cmd_due[$];
	ptt_cfg_t  live_cfg;

	logic beat_taken;
	int   send_gap = 0;
	int   hold_left = 0;
	int   jam_req;
	int   jam_seen = 0;
	bit   idle_on;
	int   bad_beats = 0;
	int   cycle_cnt;

	// One axis: Q1.16 error, deadband, rounded proportional step, slew limit, clamp.
	function automatic logic signed [ANG_W-1:0] steer_axis(
		input logic [POS_W-1:0]        pos,
		input int                      frame,
		input logic signed [ANG_W-1:0] cur,
		input ptt_axis_cfg_t           ac,
		input logic [DB_W-1:0]         db,
		input int                      lo,
		input int                      hi);
		longint unsigned twice, span, off, mag, prod;
		longint          step, lim, ang;
		bit              left;
		twice = longint'(pos) * 2;
		span  = longint'(frame);
		left  = twice < span;
		off   = left ? span - twice : twice - span;
		mag   = ((off << 17) + span) / (span * 2);
		if (mag > MAG_CEIL)
			mag = MAG_CEIL;
		if (mag < db)
			return cur;
		prod = mag * ac.gain * ac.full;
		step = longint'((prod + (64'd1 << 27)) >> 28);
		// angle moves against the error
		if (!left)
			step = -step;
		lim = longint'(ac.slew);
		if (step > lim)
			step = lim;
		else if (step < -lim)
			step = -lim;
		ang = longint'(cur) + step;
		if (ang < lo)
			ang = longint'(lo);
		else if (ang > hi)
			ang = longint'(hi);
		return ang[ANG_W-1:0];
	endfunction

	function automatic aim_t predict_aim(input sighting_t s, input ptt_cfg_t c);
		aim_t a;
		a.yaw   = steer_axis(s.x, FRAME_W, s.yaw, c.yaw, c.deadband, YAW_LO, YAW_HI);
		a.pitch = steer_axis(s.y, FRAME_H, s.pitch, c.pitch, c.deadband, PITCH_LO, PITCH_HI);
		a.move  = (a.yaw != s.yaw) || (a.pitch != s.pitch);
		return a;
	endfunction

	function automatic sighting_t random_sighting();
		sighting_t s;
		int        pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			s.x = POS_W'($urandom_range(0, (1 << POS_W) - 1));
			s.y = POS_W'($urandom_range(0, (1 << POS_W) - 1));
		end else if (pick == 1) begin
			// hover around the deadband edge
			s.x = POS_W'(FRAME_W / 2 - 24 + $urandom_range(0, 48));
			s.y = POS_W'(FRAME_H / 2 - 18 + $urandom_range(0, 36));
		end else begin
			s.x = POS_W'($urandom_range(0, FRAME_W - 1));
			s.y = POS_W'($urandom_range(0, FRAME_H - 1));
		end
		if ($urandom_range(0, 4) == 0) begin
			s.yaw   = ANG_W'($urandom_range(0, (1 << ANG_W) - 1));
			s.pitch = ANG_W'($urandom_range(0, (1 << ANG_W) - 1));
		end else begin
			s.yaw   = ANG_W'($urandom_range(0, 2 * (YAW_HI + 10)) - (YAW_HI + 10));
			s.pitch = ANG_W'($urandom_range(0, 2 * (PITCH_HI + 10)) - (PITCH_HI + 10));
		end
		return s;
	endfunction

	task automatic queue_sighting(input int x, input int y, input int yaw, input int pitch);
		sighting_t s;
		s.x     = POS_W'(x);
		s.y     = POS_W'(y);
		s.yaw   = ANG_W'(yaw);
		s.pitch = ANG_W'(pitch);
		detect_q.push_back(s);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfgw.valid <= 1'b1;
		cfgw.index <= idx;
		cfgw.data  <= val;
		do @(posedge clk); while (!cfgw.ready);
		@(negedge clk);
		cfgw.valid <= 1'b0;
	endtask

	task automatic shuffle_cfg();
		ptt_reg_t r;
		r = r.first();
		do begin
			if (r == REG_DEADBAND)
				put_reg(r, CFG_DATA_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
					: $urandom_range(0, 12000)));
			else
				put_reg(r, CFG_DATA_W'($urandom_range(0, 131071)));
			r = r.next();
		end while (r != r.first());
		if ($urandom_range(0, 1) == 0)
			put_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 131071)));
	endtask

	// every queued beat accepted and answered, then some slack
	task automatic drain();
		while (detect_q.size() != 0 || tgt.valid || cmd_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic run_batch(input int n);
		repeat (n) detect_q.push_back(random_sighting());
		drain();
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// sighting driver
	always @(negedge clk) begin
		sighting_t s;
		if (!arst_n) begin
			tgt.valid         <= 1'b0;
			tgt.target_x      <= '0;
			tgt.target_y      <= '0;
			tgt.current_yaw   <= '0;
			tgt.current_pitch <= '0;
		end else if (!(tgt.valid && !beat_taken)) begin
			if (beat_taken && idle_on && $urandom_range(0, 3) == 0)
				send_gap = $urandom_range(1, 9);
			if (send_gap > 0) begin
				send_gap--;
				tgt.valid <= 1'b0;
			end else if (detect_q.size() != 0) begin
				s = detect_q.pop_front();
				tgt.valid         <= 1'b1;
				tgt.target_x      <= s.x;
				tgt.target_y      <= s.y;
				tgt.current_yaw   <= s.yaw;
				tgt.current_pitch <= s.pitch;
			end else begin
				tgt.valid <= 1'b0;
			end
		end
	end

	// command receiver, with random stalls and the long jam on request
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd.ready <= 1'b0;
		end else begin
			if (jam_req != jam_seen) begin
				jam_seen  = jam_req;
				hold_left = JAM_CYCLES;
			end else if (hold_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				hold_left = $urandom_range(1, 9);
			end
			if (hold_left > 0) begin
				hold_left--;
				cmd.ready <= 1'b0;
			end else begin
				cmd.ready <= 1'b1;
			end
		end
	end

	// monitor: tracks register writes, predicts on input beats, checks command beats
	always @(posedge clk) begin
		sighting_t seen;
		aim_t      want;
		beat_taken <= arst_n && tgt.valid && tgt.ready;
		if (!arst_n) begin
			live_cfg.deadband   = RST_DEADBAND;
			live_cfg.yaw.gain   = RST_YAW_GAIN;
			live_cfg.yaw.full   = RST_YAW_FULL;
			live_cfg.yaw.slew   = RST_YAW_SLEW;
			live_cfg.pitch.gain = RST_PITCH_GAIN;
			live_cfg.pitch.full = RST_PITCH_FULL;
			live_cfg.pitch.slew = RST_PITCH_SLEW;
		end else begin
			if (cfgw.valid && cfgw.ready) begin
				case (cfgw.index)
					REG_DEADBAND:   live_cfg.deadband   = cfgw.data[DB_W-1:0];
					REG_YAW_GAIN:   live_cfg.yaw.gain   = cfgw.data[GAIN_W-1:0];
					REG_YAW_FULL:   live_cfg.yaw.full   = cfgw.data[STEP_W-1:0];
					REG_YAW_SLEW:   live_cfg.yaw.slew   = cfgw.data[STEP_W-1:0];
					REG_PITCH_GAIN: live_cfg.pitch.gain = cfgw.data[GAIN_W-1:0];
					REG_PITCH_FULL: live_cfg.pitch.full = cfgw.data[STEP_W-1:0];
					REG_PITCH_SLEW: live_cfg.pitch.slew = cfgw.data[STEP_W-1:0];
					default: ;
				endcase
			end
			if (tgt.valid && tgt.ready) begin
				seen.x     = tgt.target_x;
				seen.y     = tgt.target_y;
				seen.yaw   = tgt.current_yaw;
				seen.pitch = tgt.current_pitch;
				cmd_due.push_back(predict_aim(seen, live_cfg));
			end
			if (cmd.valid && cmd.ready) begin
				if (cmd_due.size() == 0) begin
					bad_beats++;
					if (bad_beats <= 10)
						$display("%0t: unexpected command beat yaw %0d pitch %0d move %0b",
							$time, cmd.next_yaw, cmd.next_pitch, cmd.should_move);
				end else begin
					want = cmd_due.pop_front();
					if (cmd.next_yaw !== want.yaw || cmd.next_pitch !== want.pitch
						|| cmd.should_move !== want.move) begin
						bad_beats++;
						if (bad_beats <= 10)
							$display("%0t: mismatch, want %0d %0d %0b, got %0d %0d %0b",
								$time, want.yaw, want.pitch, want.move,
								cmd.next_yaw, cmd.next_pitch, cmd.should_move);
					end
				end
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfgw.valid         = 1'b0;
		cfgw.index         = '0;
		cfgw.data          = '0;
		jam_req            = 0;
		idle_on            = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: centre, corners, deadband edges, angle clamps
		queue_sighting(160, 120, 0, 0);
		queue_sighting(0, 0, 0, 0);
		queue_sighting(1023, 1023, 0, 0);
		queue_sighting(176, 132, 10, -10);
		queue_sighting(175, 131, 10, -10);
		queue_sighting(144, 108, -10, 10);
		queue_sighting(145, 109, -10, 10);
		queue_sighting(0, 0, 88, 28);
		queue_sighting(1023, 1023, -88, -28);
		queue_sighting(160, 120, -2048, 2047);
		queue_sighting(1023, 0, 2047, -2048);
		queue_sighting(0, 1023, -2048, 2047);
		queue_sighting(319, 239, 90, 30);
		queue_sighting(320, 240, -90, -30);
		queue_sighting(161, 121, 0, 0);
		run_batch(80);

		// all ones, upper data bits beyond each register dropped; stray index ignored
		put_reg(REG_DEADBAND, 17'h1FFFF);
		put_reg(REG_YAW_GAIN, 17'h1FFFF);
		put_reg(REG_YAW_FULL, 17'h1FFFF);
		put_reg(REG_YAW_SLEW, 17'h1FFFF);
		put_reg(REG_PITCH_GAIN, 17'h1FFFF);
		put_reg(REG_PITCH_FULL, 17'h1FFFF);
		put_reg(REG_PITCH_SLEW, 17'h1FFFF);
		put_reg(REG_UNUSED, 17'h00000);
		queue_sighting(1023, 1023, 0, 0);
		queue_sighting(0, 0, 0, 0);
		run_batch(70);

		// zero gain on yaw, zero slew on pitch, deadband of 1.0
		put_reg(REG_DEADBAND, 17'd65536);
		put_reg(REG_YAW_GAIN, 17'd0);
		put_reg(REG_YAW_FULL, 17'd1023);
		put_reg(REG_YAW_SLEW, 17'd1023);
		put_reg(REG_PITCH_GAIN, 17'd65535);
		put_reg(REG_PITCH_FULL, 17'd1023);
		put_reg(REG_PITCH_SLEW, 17'd0);
		queue_sighting(0, 0, 0, 0);
		queue_sighting(1023, 1023, 0, 0);
		run_batch(60);

		// no deadband, zero full-scale on yaw, tiny pitch step
		put_reg(REG_DEADBAND, 17'd0);
		put_reg(REG_YAW_GAIN, 17'd4096);
		put_reg(REG_YAW_FULL, 17'd0);
		put_reg(REG_YAW_SLEW, 17'd7);
		put_reg(REG_PITCH_GAIN, 17'd12288);
		put_reg(REG_PITCH_FULL, 17'd3);
		put_reg(REG_PITCH_SLEW, 17'd1023);
		run_batch(40);

		// jam the receiver while sightings keep coming, to fill the pipe
		idle_on = 1'b0;
		jam_req++;
		run_batch(50);
		idle_on = 1'b1;

		repeat (4) begin
			shuffle_cfg();
			run_batch(40);
		end

		idle_on = 1'b0;
		shuffle_cfg();
		run_batch(60);

		if (bad_beats == 0 && cmd_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_in_if.sv
hw/rtl/ptt_out_if.sv
hw/rtl/ptt_cfg_if.sv
hw/rtl/ptt_cfg_regs.sv
hw/rtl/ptt_axis.sv
hw/rtl/pan_tilt_target_tracker.sv
tb/tb_pan_tilt_target_tracker.sv
